/* rtl/gregorian_date_advance_core_macros.svh */
// assertion macros shared by the date core checker
// relies on i_clk and i_rst_n being visible where a macro is used
`ifndef GREGORIAN_DATE_ADVANCE_CORE_MACROS_SVH
`define GREGORIAN_DATE_ADVANCE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define GDA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("date core check failed");

// next-cycle implication, disabled during reset
`define GDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("date core check failed");

`endif

/* rtl/gda_pkg.sv */
// types, codes, microcode program and calendar helpers for the date core
// no dependencies
package gda_pkg;

    // default widths
    localparam int YEAR_BITS_DEF    = 12;
    localparam int ADVANCE_BITS_DEF = 16;

    // fixed field widths
    localparam int CMD_BITS    = 2;
    localparam int MONTH_BITS  = 4;
    localparam int DAY_BITS    = 5;
    localparam int DOY_BITS    = 9;
    localparam int STATUS_BITS = 2;
    localparam int CYC_BITS    = 9;   // year position within the 400-year cycle

    // calendar constants
    localparam int YEAR_MIN    = 1900;
    localparam int LEAP_CYCLE  = 400;
    localparam int CENTURY     = 100;
    localparam int MONTHS      = 12;
    localparam int CYC_RESET   = YEAR_MIN % LEAP_CYCLE;

    // command codes
    localparam logic [CMD_BITS-1:0] CMD_SET  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_ADV  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_READ = 2'd2;

    // status codes
    localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_BAD  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_OVER = 2'd2;

    // microcode layout
    localparam int UPC_BITS  = 4;
    localparam int OP_BITS   = 4;
    localparam int COND_BITS = 4;

    // datapath operations
    localparam logic [OP_BITS-1:0] OP_NOP        = 4'd0;
    localparam logic [OP_BITS-1:0] OP_LOAD_SET   = 4'd1;
    localparam logic [OP_BITS-1:0] OP_SUB_CYCLE  = 4'd2;
    localparam logic [OP_BITS-1:0] OP_COMMIT_SET = 4'd3;
    localparam logic [OP_BITS-1:0] OP_REJECT     = 4'd4;
    localparam logic [OP_BITS-1:0] OP_ORD_INIT   = 4'd5;
    localparam logic [OP_BITS-1:0] OP_ORD_ADD    = 4'd6;
    localparam logic [OP_BITS-1:0] OP_ORD_STORE  = 4'd7;
    localparam logic [OP_BITS-1:0] OP_ADV_INIT   = 4'd8;
    localparam logic [OP_BITS-1:0] OP_WALK       = 4'd9;
    localparam logic [OP_BITS-1:0] OP_COMMIT_ADV = 4'd10;
    localparam logic [OP_BITS-1:0] OP_FINISH     = 4'd11;

    // jump conditions
    localparam logic [COND_BITS-1:0] C_NEVER    = 4'd0;
    localparam logic [COND_BITS-1:0] C_ALWAYS   = 4'd1;
    localparam logic [COND_BITS-1:0] C_IS_SET   = 4'd2;
    localparam logic [COND_BITS-1:0] C_IS_ADV   = 4'd3;
    localparam logic [COND_BITS-1:0] C_SET_BAD  = 4'd4;
    localparam logic [COND_BITS-1:0] C_REM_GE   = 4'd5;
    localparam logic [COND_BITS-1:0] C_DAY_GT   = 4'd6;
    localparam logic [COND_BITS-1:0] C_WM_LT    = 4'd7;
    localparam logic [COND_BITS-1:0] C_WALK     = 4'd8;
    localparam logic [COND_BITS-1:0] C_OVER     = 4'd9;
    localparam logic [COND_BITS-1:0] C_OUT_FULL = 4'd10;

    // program entry points
    localparam logic [UPC_BITS-1:0] A_DISPATCH = 4'd0;
    localparam logic [UPC_BITS-1:0] A_SET      = 4'd3;
    localparam logic [UPC_BITS-1:0] A_CYCLE    = 4'd4;
    localparam logic [UPC_BITS-1:0] A_REJECT   = 4'd7;
    localparam logic [UPC_BITS-1:0] A_ORD      = 4'd8;
    localparam logic [UPC_BITS-1:0] A_ORD_LOOP = 4'd9;
    localparam logic [UPC_BITS-1:0] A_ADV      = 4'd11;
    localparam logic [UPC_BITS-1:0] A_WALK     = 4'd12;
    localparam logic [UPC_BITS-1:0] A_DONE     = 4'd15;

    typedef struct packed {
        logic [OP_BITS-1:0]   op;
        logic [COND_BITS-1:0] cond;
        logic [UPC_BITS-1:0]  target;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        logic               load;
        logic [OP_BITS-1:0] op;
    } t_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic is_set;
        logic is_adv;
        logic set_bad;
        logic rem_ge;
        logic day_gt;
        logic wm_lt;
        logic walk_more;
        logic over;
        logic out_free;
    } t_flags;

    // control store: one word per step, jump taken when cond holds
    function automatic t_uword ucode_rom(input logic [UPC_BITS-1:0] pc);
        t_uword w;
        unique case (pc)
            4'd0:    w = '{op: OP_NOP,        cond: C_IS_SET,   target: A_SET};
            4'd1:    w = '{op: OP_NOP,        cond: C_IS_ADV,   target: A_ADV};
            4'd2:    w = '{op: OP_NOP,        cond: C_ALWAYS,   target: A_DONE};
            4'd3:    w = '{op: OP_LOAD_SET,   cond: C_SET_BAD,  target: A_REJECT};
            4'd4:    w = '{op: OP_SUB_CYCLE,  cond: C_REM_GE,   target: A_CYCLE};
            4'd5:    w = '{op: OP_NOP,        cond: C_DAY_GT,   target: A_REJECT};
            4'd6:    w = '{op: OP_COMMIT_SET, cond: C_ALWAYS,   target: A_ORD};
            4'd7:    w = '{op: OP_REJECT,     cond: C_ALWAYS,   target: A_DONE};
            4'd8:    w = '{op: OP_ORD_INIT,   cond: C_NEVER,    target: A_DISPATCH};
            4'd9:    w = '{op: OP_ORD_ADD,    cond: C_WM_LT,    target: A_ORD_LOOP};
            4'd10:   w = '{op: OP_ORD_STORE,  cond: C_ALWAYS,   target: A_DONE};
            4'd11:   w = '{op: OP_ADV_INIT,   cond: C_NEVER,    target: A_DISPATCH};
            4'd12:   w = '{op: OP_WALK,       cond: C_WALK,     target: A_WALK};
            4'd13:   w = '{op: OP_NOP,        cond: C_OVER,     target: A_DONE};
            4'd14:   w = '{op: OP_COMMIT_ADV, cond: C_ALWAYS,   target: A_ORD};
            4'd15:   w = '{op: OP_FINISH,     cond: C_OUT_FULL, target: A_DONE};
            default: w = '{op: OP_NOP,        cond: C_ALWAYS,   target: A_DONE};
        endcase
        return w;
    endfunction

    // leap rule on the year's position in the 400-year cycle
    function automatic logic leap_of(input logic [CYC_BITS-1:0] cyc);
        return (cyc[1:0] == 2'b00) &&
               (cyc != CYC_BITS'(CENTURY)) &&
               (cyc != CYC_BITS'(2 * CENTURY)) &&
               (cyc != CYC_BITS'(3 * CENTURY));
    endfunction

    function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                      input logic leap);
        logic [DAY_BITS-1:0] len;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* rtl/gda_if.sv */
// item channels of the date core: command in, dated result out
// depends on gda_pkg
interface gda_in_if import gda_pkg::*; #(
    parameter int YEAR_BITS    = YEAR_BITS_DEF,
    parameter int ADVANCE_BITS = ADVANCE_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [CMD_BITS-1:0]     command;
    logic [MONTH_BITS-1:0]   new_month;
    logic [DAY_BITS-1:0]     new_day;
    logic [YEAR_BITS-1:0]    new_year;
    logic [ADVANCE_BITS-1:0] advance_days;

    modport source (output valid, command, new_month, new_day, new_year, advance_days,
                    input ready);
    modport sink   (input valid, command, new_month, new_day, new_year, advance_days,
                    output ready);
endinterface

interface gda_out_if import gda_pkg::*; #(
    parameter int YEAR_BITS = YEAR_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [MONTH_BITS-1:0]  cur_month;
    logic [DAY_BITS-1:0]    cur_day;
    logic [YEAR_BITS-1:0]   cur_year;
    logic [DOY_BITS-1:0]    day_of_year;
    logic                   leap_year;
    logic [STATUS_BITS-1:0] status;

    modport source (output valid, cur_month, cur_day, cur_year, day_of_year, leap_year,
                    status, input ready);
    modport sink   (input valid, cur_month, cur_day, cur_year, day_of_year, leap_year,
                    status, output ready);
endinterface

/* rtl/gda_seq.sv */
// microcode sequencer: step counter, control store lookup, conditional jumps
// depends on gda_pkg
module gda_seq import gda_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_flags i_flags,
    output t_ctrl  o_ctrl
);

    logic                r_busy;
    logic [UPC_BITS-1:0] r_pc;
    t_uword              w_uw;
    logic                w_take;
    logic                w_accept;

    // current control word
    always_comb begin
        w_uw = ucode_rom(r_pc);
    end

    // jump condition select
    always_comb begin
        unique case (w_uw.cond)
            C_NEVER:    w_take = 1'b0;
            C_ALWAYS:   w_take = 1'b1;
            C_IS_SET:   w_take = i_flags.is_set;
            C_IS_ADV:   w_take = i_flags.is_adv;
            C_SET_BAD:  w_take = i_flags.set_bad;
            C_REM_GE:   w_take = i_flags.rem_ge;
            C_DAY_GT:   w_take = i_flags.day_gt;
            C_WM_LT:    w_take = i_flags.wm_lt;
            C_WALK:     w_take = i_flags.walk_more;
            C_OVER:     w_take = i_flags.over;
            C_OUT_FULL: w_take = !i_flags.out_free;
            default:    w_take = 1'b0;
        endcase
    end

    assign w_accept   = i_in_valid && !r_busy;
    assign o_in_ready = !r_busy;
    assign o_ctrl.load = w_accept;
    assign o_ctrl.op   = r_busy ? w_uw.op : OP_NOP;

    // step counter and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= A_DISPATCH;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_pc   <= A_DISPATCH;
        end else if (r_busy) begin
            r_pc <= w_take ? w_uw.target : r_pc + 1'b1;
            if (w_uw.op == OP_FINISH && i_flags.out_free) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

/* rtl/gda_dp.sv */
// datapath: stored date, working registers, month-length units, result register
// depends on gda_pkg
module gda_dp import gda_pkg::*; #(
    parameter int YEAR_BITS    = YEAR_BITS_DEF,
    parameter int ADVANCE_BITS = ADVANCE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctrl                   i_ctrl,
    input  logic [CMD_BITS-1:0]     i_command,
    input  logic [MONTH_BITS-1:0]   i_new_month,
    input  logic [DAY_BITS-1:0]     i_new_day,
    input  logic [YEAR_BITS-1:0]    i_new_year,
    input  logic [ADVANCE_BITS-1:0] i_advance_days,
    input  logic                    i_out_ready,
    output t_flags                  o_flags,
    output logic                    o_out_valid,
    output logic [MONTH_BITS-1:0]   o_cur_month,
    output logic [DAY_BITS-1:0]     o_cur_day,
    output logic [YEAR_BITS-1:0]    o_cur_year,
    output logic [DOY_BITS-1:0]     o_day_of_year,
    output logic                    o_leap_year,
    output logic [STATUS_BITS-1:0]  o_status
);

    // running day total: day of year plus the largest advance
    localparam int TotBits = ((ADVANCE_BITS > DOY_BITS) ? ADVANCE_BITS : DOY_BITS) + 1;
    localparam logic [YEAR_BITS-1:0] YearTop = {YEAR_BITS{1'b1}};

    // stored date
    logic [MONTH_BITS-1:0]   r_month;
    logic [DAY_BITS-1:0]     r_day;
    logic [YEAR_BITS-1:0]    r_year;
    logic [CYC_BITS-1:0]     r_cyc;
    logic [DOY_BITS-1:0]     r_doy;

    // latched item
    logic [CMD_BITS-1:0]     r_cmd;
    logic [MONTH_BITS-1:0]   r_nm;
    logic [DAY_BITS-1:0]     r_nd;
    logic [YEAR_BITS-1:0]    r_ny;
    logic [ADVANCE_BITS-1:0] r_adv;

    // working registers
    logic [YEAR_BITS-1:0]    r_rem;
    logic [TotBits-1:0]      r_acc;
    logic [MONTH_BITS-1:0]   r_wm;
    logic [YEAR_BITS-1:0]    r_wy;
    logic [CYC_BITS-1:0]     r_wcyc;
    logic [STATUS_BITS-1:0]  r_status;

    // result register
    logic                    r_out_valid;
    logic [MONTH_BITS-1:0]   r_o_month;
    logic [DAY_BITS-1:0]     r_o_day;
    logic [YEAR_BITS-1:0]    r_o_year;
    logic [DOY_BITS-1:0]     r_o_doy;
    logic                    r_o_leap;
    logic [STATUS_BITS-1:0]  r_o_status;

    logic [DAY_BITS-1:0]     w_len_set;
    logic [DAY_BITS-1:0]     w_len_walk;
    logic                    w_at_top;
    logic                    w_past_month;
    logic                    w_out_free;
    logic                    w_finish;

    // month lengths for the set check and for the walk
    assign w_len_set    = month_len(r_nm, leap_of(r_rem[CYC_BITS-1:0]));
    assign w_len_walk   = month_len(r_wm, leap_of(r_wcyc));
    assign w_at_top     = (r_wm == MONTH_BITS'(MONTHS)) && (r_wy == YearTop);
    assign w_past_month = r_acc > TotBits'(w_len_walk);
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_finish     = (i_ctrl.op == OP_FINISH) && w_out_free;

    // condition flags
    assign o_flags.is_set    = (r_cmd == CMD_SET);
    assign o_flags.is_adv    = (r_cmd == CMD_ADV);
    assign o_flags.set_bad   = (r_nm == '0) || (r_nm > MONTH_BITS'(MONTHS)) ||
                               (r_nd == '0) || (r_ny < YEAR_BITS'(YEAR_MIN));
    assign o_flags.rem_ge    = r_rem >= YEAR_BITS'(LEAP_CYCLE);
    assign o_flags.day_gt    = r_nd > w_len_set;
    assign o_flags.wm_lt     = r_wm < r_month;
    assign o_flags.walk_more = w_past_month && !w_at_top;
    assign o_flags.over      = (r_status == ST_OVER);
    assign o_flags.out_free  = w_out_free;

    // stored date and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_month     <= MONTH_BITS'(1);
            r_day       <= DAY_BITS'(1);
            r_year      <= YEAR_BITS'(YEAR_MIN);
            r_cyc       <= CYC_BITS'(CYC_RESET);
            r_doy       <= DOY_BITS'(1);
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_ctrl.op)
                OP_COMMIT_SET: begin
                    r_month <= r_nm;
                    r_day   <= r_nd;
                    r_year  <= r_ny;
                    r_cyc   <= r_rem[CYC_BITS-1:0];
                end
                OP_COMMIT_ADV: begin
                    r_month <= r_wm;
                    r_day   <= r_acc[DAY_BITS-1:0];
                    r_year  <= r_wy;
                    r_cyc   <= r_wcyc;
                end
                OP_ORD_STORE: begin
                    r_doy <= r_acc[DOY_BITS-1:0];
                end
                default: begin
                end
            endcase
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // latched item, working registers and result payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd    <= i_command;
            r_nm     <= i_new_month;
            r_nd     <= i_new_day;
            r_ny     <= i_new_year;
            r_adv    <= i_advance_days;
            r_status <= ST_OK;
        end
        unique case (i_ctrl.op)
            OP_LOAD_SET: begin
                r_rem <= r_ny;
            end
            OP_SUB_CYCLE: begin
                if (r_rem >= YEAR_BITS'(LEAP_CYCLE)) begin
                    r_rem <= r_rem - YEAR_BITS'(LEAP_CYCLE);
                end
            end
            OP_REJECT: begin
                r_status <= ST_BAD;
            end
            OP_ORD_INIT: begin
                r_acc  <= TotBits'(r_day);
                r_wm   <= MONTH_BITS'(1);
                r_wcyc <= r_cyc;
            end
            OP_ORD_ADD: begin
                if (r_wm < r_month) begin
                    r_acc <= r_acc + TotBits'(w_len_walk);
                    r_wm  <= r_wm + 1'b1;
                end
            end
            OP_ADV_INIT: begin
                r_acc  <= TotBits'(r_doy) + TotBits'(r_adv);
                r_wm   <= MONTH_BITS'(1);
                r_wy   <= r_year;
                r_wcyc <= r_cyc;
            end
            OP_WALK: begin
                if (w_past_month) begin
                    if (w_at_top) begin
                        r_status <= ST_OVER;
                    end else begin
                        r_acc <= r_acc - TotBits'(w_len_walk);
                        if (r_wm == MONTH_BITS'(MONTHS)) begin
                            r_wm   <= MONTH_BITS'(1);
                            r_wy   <= r_wy + 1'b1;
                            r_wcyc <= (r_wcyc == CYC_BITS'(LEAP_CYCLE - 1)) ? '0
                                                                            : r_wcyc + 1'b1;
                        end else begin
                            r_wm <= r_wm + 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        if (w_finish) begin
            r_o_month  <= r_month;
            r_o_day    <= r_day;
            r_o_year   <= r_year;
            r_o_doy    <= r_doy;
            r_o_leap   <= leap_of(r_cyc);
            r_o_status <= r_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cur_month   = r_o_month;
    assign o_cur_day     = r_o_day;
    assign o_cur_year    = r_o_year;
    assign o_day_of_year = r_o_doy;
    assign o_leap_year   = r_o_leap;
    assign o_status      = r_o_status;

endmodule

/* rtl/gregorian_date_advance_core.sv */
// channel    dir  handshake     payload
// i_in       in   valid/ready   command, new_month, new_day, new_year, advance_days
// o_out      out  valid/ready   cur_month, cur_day, cur_year, day_of_year, leap_year, status
//
// one item at a time, run by a 16-step microprogram over two month-length units
// read reports the stored date; set reduces the year in 400-year steps, checks the day
// against the month length, stores the date and sums month lengths for the ordinal day;
// a set failing the range or day check is rejected; advance walks months from january,
// stores the date and recomputes the ordinal day; on overflow the stored date is kept
// synchronous active-low reset; result held in an output register until taken,
// and the next item is taken while it waits; a stalled output holds the last step
// top level of the date core: sequencer plus datapath
// depends on gda_pkg, gda_if, gda_seq, gda_dp
module gregorian_date_advance_core import gda_pkg::*; #(
    parameter int YEAR_BITS    = YEAR_BITS_DEF,
    parameter int ADVANCE_BITS = ADVANCE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gda_in_if.sink    i_in,
    gda_out_if.source o_out
);

    t_ctrl  w_ctrl;
    t_flags w_flags;

    // step counter and control store
    gda_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_flags    (w_flags),
        .o_ctrl     (w_ctrl)
    );

    // date registers and arithmetic
    gda_dp #(
        .YEAR_BITS    (YEAR_BITS),
        .ADVANCE_BITS (ADVANCE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .i_command      (i_in.command),
        .i_new_month    (i_in.new_month),
        .i_new_day      (i_in.new_day),
        .i_new_year     (i_in.new_year),
        .i_advance_days (i_in.advance_days),
        .i_out_ready    (o_out.ready),
        .o_flags        (w_flags),
        .o_out_valid    (o_out.valid),
        .o_cur_month    (o_out.cur_month),
        .o_cur_day      (o_out.cur_day),
        .o_cur_year     (o_out.cur_year),
        .o_day_of_year  (o_out.day_of_year),
        .o_leap_year    (o_out.leap_year),
        .o_status       (o_out.status)
    );

endmodule

/* rtl/gda_checker.sv */
// port-level checks on the date core, attached by bind
// depends on gda_pkg and gregorian_date_advance_core_macros.svh
`include "gregorian_date_advance_core_macros.svh"

module gda_checker import gda_pkg::*; #(
    parameter int YEAR_BITS = YEAR_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [MONTH_BITS-1:0]  i_cur_month,
    input logic [DAY_BITS-1:0]    i_cur_day,
    input logic [YEAR_BITS-1:0]   i_cur_year,
    input logic [DOY_BITS-1:0]    i_day_of_year,
    input logic                   i_leap_year
);

    // a waiting result stays offered
    `GDA_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)

    // an accepted item makes the core busy on the next cycle
    `GDA_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready)

    // in january the ordinal day equals the day of month
    `GDA_ASSERT_NOW(a_jan_doy, i_out_valid && i_cur_month == 4'd1,
                    i_day_of_year == 9'(i_cur_day))

    // leap flag only on years divisible by four
    `GDA_ASSERT_NOW(a_leap_div4, i_out_valid && i_leap_year, i_cur_year[1:0] == 2'b00)

endmodule

bind gregorian_date_advance_core gda_checker #(
    .YEAR_BITS (YEAR_BITS)
) u_gda_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_cur_month   (o_out.cur_month),
    .i_cur_day     (o_out.cur_day),
    .i_cur_year    (o_out.cur_year),
    .i_day_of_year (o_out.day_of_year),
    .i_leap_year   (o_out.leap_year)
);
